// ----- hw/rtl/csm_pkg.sv -----
// Package with shared constants, operation codes and interface types for the slot manager.
`timescale 1ns / 1ps

package csm_pkg;

    localparam int SLOTS   = 4;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int STAMP_W = 32;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 2;

    localparam logic [OP_W-1:0] OP_BEGIN   = 2'd0;
    localparam logic [OP_W-1:0] OP_COMMIT  = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    // Write request into the slot store
    typedef struct packed {
        logic               en;
        logic [SLOT_W-1:0]  addr;
        logic               write_stamp;
        logic [STAMP_W-1:0] stamp;
        logic               complete;
    } store_wr_t;

    // Result of the shared stamp comparator
    typedef struct packed {
        logic lt;
        logic gt;
    } cmp_res_t;

    // Keep the low bits of a slot number for the result field
    function automatic logic [IDX_W-1:0] out_idx(input logic [SLOT_W-1:0] idx);
        logic [15:0] wide;
        wide = 16'(idx);
        return wide[IDX_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/csm_cmp.sv -----
// Shared 32-bit stamp comparator used by the begin and restore scan steps.
`timescale 1ns / 1ps

module csm_cmp
    import csm_pkg::*;
(
    input  logic [STAMP_W-1:0] a,
    input  logic [STAMP_W-1:0] b,
    output cmp_res_t           res
);

    always_comb
    begin
        res.lt = (a < b);
        res.gt = (a > b);
    end

endmodule

// ----- hw/rtl/csm_slot_store.sv -----
// Slot store: complete flags and progress stamps, one read and one write port.
`timescale 1ns / 1ps

module csm_slot_store
    import csm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SLOT_W-1:0]  rd_addr,
    output logic               rd_complete,
    output logic [STAMP_W-1:0] rd_stamp,
    input  store_wr_t          wr
);

    logic [SLOTS-1:0]   complete_reg;
    logic [STAMP_W-1:0] stamp_reg [SLOTS];

    assign rd_complete = complete_reg[rd_addr];
    assign rd_stamp    = stamp_reg[rd_addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            complete_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            complete_reg[wr.addr] <= wr.complete;
            if (wr.write_stamp)
            begin
                stamp_reg[wr.addr] <= wr.stamp;
            end
        end
    end

endmodule

// ----- hw/rtl/checkpoint_slot_manager_core.sv -----
// Steps: begin is accepted, scans from the first slot up to all SLOTS slots, then finishes.
// Commit reads only the current slot, restore scans every slot, an unknown operation goes straight to finish.
// The scan reads the slot store one slot per cycle through one shared comparator,
// so a new transaction is taken only once the last has finished; input is held off until finish.
// The result sits in an output register; the next transaction is accepted meanwhile.
// Reset (rst_n low, asynchronous) clears all flags, stamps and the current slot.
`timescale 1ns / 1ps

module checkpoint_slot_manager_core
    import csm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [1:0] operation, [33:2] progress_stamp, [39:34] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // [1:0] slot_index, [2] found, [34:3] slot_stamp, zero above
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t             state_reg,   state_next;
    logic [OP_W-1:0]    op_reg,      op_next;
    logic [STAMP_W-1:0] stamp_reg,   stamp_next;
    logic [SLOT_W-1:0]  idx_reg,     idx_next;
    logic [SLOT_W-1:0]  pick_reg,    pick_next;
    logic [STAMP_W-1:0] best_reg,    best_next;
    logic               hit_reg,     hit_next;
    logic [SLOT_W-1:0]  cur_reg,     cur_next;
    logic               m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]   o_idx_reg,   o_idx_next;
    logic               o_found_reg, o_found_next;
    logic [STAMP_W-1:0] o_stamp_reg, o_stamp_next;

    logic               rd_complete;
    logic [STAMP_W-1:0] rd_stamp;
    logic [SLOT_W-1:0]  rd_addr;
    store_wr_t          wr;
    cmp_res_t           cmp;
    logic               last;
    logic               in_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, o_stamp_reg, o_found_reg, o_idx_reg};
    assign rd_addr  = (op_reg == OP_COMMIT) ? cur_reg : idx_reg;
    assign last     = (idx_reg == SLOT_W'(SLOTS - 1));

    csm_slot_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_addr     (rd_addr),
        .rd_complete (rd_complete),
        .rd_stamp    (rd_stamp),
        .wr          (wr)
    );

    csm_cmp u_cmp (
        .a   (rd_stamp),
        .b   (best_reg),
        .res (cmp)
    );

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        stamp_next   = stamp_reg;
        idx_next     = idx_reg;
        pick_next    = pick_reg;
        best_next    = best_reg;
        hit_next     = hit_reg;
        cur_next     = cur_reg;
        o_idx_next   = o_idx_reg;
        o_found_next = o_found_reg;
        o_stamp_next = o_stamp_reg;
        m_valid_next = m_valid_reg && !m_tready;
        wr           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = s_tdata[1:0];
                    stamp_next = s_tdata[33:2];
                    idx_next   = '0;
                    pick_next  = '0;
                    hit_next   = 1'b0;
                    best_next  = (s_tdata[1:0] == OP_BEGIN) ? STAMP_MAX : '0;
                    if (s_tdata[1:0] == OP_BEGIN || s_tdata[1:0] == OP_COMMIT ||
                        s_tdata[1:0] == OP_RESTORE)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_SCAN:
            begin
                case (op_reg)
                    OP_BEGIN:
                    begin
                        if (!rd_complete)
                        begin
                            // first free slot wins outright
                            pick_next  = idx_reg;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            if (cmp.lt)
                            begin
                                best_next = rd_stamp;
                                pick_next = idx_reg;
                            end
                            if (last)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                idx_next = idx_reg + 1'b1;
                            end
                        end
                    end
                    OP_COMMIT:
                    begin
                        best_next  = rd_stamp;
                        pick_next  = cur_reg;
                        state_next = ST_FINISH;
                    end
                    OP_RESTORE:
                    begin
                        if (rd_complete && cmp.gt)
                        begin
                            best_next = rd_stamp;
                            pick_next = idx_reg;
                            hit_next  = 1'b1;
                        end
                        if (last)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_FINISH:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    case (op_reg)
                        OP_BEGIN:
                        begin
                            o_idx_next     = out_idx(pick_reg);
                            o_found_next   = 1'b1;
                            o_stamp_next   = stamp_reg;
                            cur_next       = pick_reg;
                            wr.en          = 1'b1;
                            wr.addr        = pick_reg;
                            wr.write_stamp = 1'b1;
                            wr.stamp       = stamp_reg;
                            wr.complete    = 1'b0;
                        end
                        OP_COMMIT:
                        begin
                            o_idx_next   = out_idx(pick_reg);
                            o_found_next = 1'b1;
                            o_stamp_next = best_reg;
                            wr.en        = 1'b1;
                            wr.addr      = pick_reg;
                            wr.complete  = 1'b1;
                        end
                        OP_RESTORE:
                        begin
                            o_idx_next   = hit_reg ? out_idx(pick_reg) : '0;
                            o_found_next = hit_reg;
                            o_stamp_next = hit_reg ? best_reg : '0;
                        end
                        default:
                        begin
                            o_idx_next   = '0;
                            o_found_next = 1'b0;
                            o_stamp_next = '0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= '0;
            stamp_reg   <= '0;
            idx_reg     <= '0;
            pick_reg    <= '0;
            best_reg    <= '0;
            hit_reg     <= 1'b0;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
            o_idx_reg   <= '0;
            o_found_reg <= 1'b0;
            o_stamp_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            stamp_reg   <= stamp_next;
            idx_reg     <= idx_next;
            pick_reg    <= pick_next;
            best_reg    <= best_next;
            hit_reg     <= hit_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
            o_idx_reg   <= o_idx_next;
            o_found_reg <= o_found_next;
            o_stamp_reg <= o_stamp_next;
        end
    end

endmodule

// ----- hw/rtl/csm_checker.sv -----
// Port-level checker for the slot manager, bound to the top level.
`timescale 1ns / 1ps

module csm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // acceptance is never back to back: an accepted transaction drops s_tready
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // a miss reports slot zero and stamp zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[1:0] == 2'd0 && m_tdata[34:3] == 32'd0)
        else $error("miss with nonzero slot or stamp");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[39:35] == 5'd0)
        else $error("nonzero padding in result");

endmodule

bind checkpoint_slot_manager_core csm_checker u_csm_checker (.*);

// ----- sim/checkpoint_slot_manager_core_test.sv -----
// Self-checking testbench for the checkpoint slot manager core: directed table, then random traffic.
`timescale 1ns / 1ps

module checkpoint_slot_manager_core_test;
    import csm_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 1150;
    localparam int MAX_WAIT     = 10;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4 * (SLOTS + 4);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic               found;
        logic [IDX_W-1:0]   idx;
    } slot_result_t;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [STAMP_W-1:0] stamp;
        bit                 typed;
        slot_result_t       want;
    } stim_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // [1:0] operation, [33:2] progress_stamp, [39:34] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [1:0] slot_index, [2] found, [34:3] slot_stamp, zero above

    // Predictor state
    logic               slot_done_m  [SLOTS];
    logic [STAMP_W-1:0] slot_stamp_m [SLOTS];
    int                 cur_slot_m;

    slot_result_t slot_results_due [$];
    stim_row_t    stim_table [$];

    int  fail_count      = 0;
    int  results_checked = 0;
    int  cycle_count     = 0;
    int  op_counts [4]   = '{0, 0, 0, 0};
    bit  send_calm       = 1'b0;
    bit  recv_calm       = 1'b0;
    bit  hold_done       = 1'b0;

    checkpoint_slot_manager_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 slot_results_due.size());
        $display("TB_ERROR");
        $finish;
    end

    function automatic slot_result_t slot_op_predict(input logic [OP_W-1:0] op,
                                                     input logic [STAMP_W-1:0] stamp);
        slot_result_t       res;
        logic [STAMP_W-1:0] low;
        int                 pick;
        bit                 searching;
        bit                 hit;
        res = '0;
        case (op)
            OP_BEGIN:
            begin
                pick      = 0;
                low       = STAMP_MAX;
                searching = 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (searching)
                    begin
                        if (!slot_done_m[i])
                        begin
                            pick      = i;
                            searching = 1'b0;
                        end
                        else if (slot_stamp_m[i] < low)
                        begin
                            low  = slot_stamp_m[i];
                            pick = i;
                        end
                    end
                end
                cur_slot_m         = pick;
                slot_done_m[pick]  = 1'b0;
                slot_stamp_m[pick] = stamp;
                res.idx   = IDX_W'(pick);
                res.found = 1'b1;
                res.stamp = stamp;
            end
            OP_COMMIT:
            begin
                slot_done_m[cur_slot_m] = 1'b1;
                res.idx   = IDX_W'(cur_slot_m);
                res.found = 1'b1;
                res.stamp = slot_stamp_m[cur_slot_m];
            end
            OP_RESTORE:
            begin
                hit = 1'b0;
                low = '0;
                pick = 0;
                // strict compare keeps the lowest index on ties and skips zero stamps
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_done_m[i] && slot_stamp_m[i] > low)
                    begin
                        low  = slot_stamp_m[i];
                        pick = i;
                        hit  = 1'b1;
                    end
                end
                if (hit)
                begin
                    res.idx   = IDX_W'(pick);
                    res.found = 1'b1;
                    res.stamp = low;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic logic [STAMP_W-1:0] random_stamp();
        logic [STAMP_W-1:0] val;
        case ($urandom_range(0, 9))
            0:       val = '0;
            1:       val = STAMP_MAX;
            2, 3:    val = STAMP_W'($urandom_range(0, 7));  // small values force ties
            default: val = $urandom;
        endcase
        return val;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] stamp,
                           input bit typed, input logic [IDX_W-1:0] idx, input logic found,
                           input logic [STAMP_W-1:0] want_stamp);
        stim_row_t row;
        row.op         = op;
        row.stamp      = stamp;
        row.typed      = typed;
        row.want.idx   = idx;
        row.want.found = found;
        row.want.stamp = want_stamp;
        stim_table.push_back(row);
    endtask

    // Entered at a falling edge; leaves at the falling edge after acceptance.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] stamp,
                             input bit typed, input slot_result_t want);
        int           gap;
        slot_result_t predicted;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, stamp, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = slot_op_predict(op, stamp);
        slot_results_due.push_back(typed ? want : predicted);
        op_counts[op]++;
        @(negedge clk);
    endtask

    // Result side
    initial
    begin
        int           stall;
        slot_result_t want;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_calm = !recv_calm;
            if (!hold_done && results_checked >= HOLD_AFTER)
            begin
                // long hold so the block fills up and stalls its input
                hold_done = 1'b1;
                stall     = HOLD_CYCLES;
            end
            else
                stall = draw_wait(recv_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                while (stall > 0)
                begin
                    @(negedge clk);
                    stall--;
                end
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            results_checked++;
            if (slot_results_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result transaction: tdata=%h", m_tdata);
            end
            else
            begin
                want = slot_results_due.pop_front();
                if (m_tdata[1:0] !== want.idx || m_tdata[2] !== want.found ||
                    m_tdata[34:3] !== want.stamp)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("result %0d mismatch: idx %0d/%0d found %0d/%0d stamp %h/%h",
                                 results_checked, m_tdata[1:0], want.idx, m_tdata[2],
                                 want.found, m_tdata[34:3], want.stamp);
                end
            end
            @(negedge clk);
        end
    end

    // Reset, directed table, random traffic, drain
    initial
    begin
        int           sent;
        int           kind;
        slot_result_t none;
        none = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_done_m[i]  = 1'b0;
            slot_stamp_m[i] = '0;
        end
        cur_slot_m = 0;

        // empty store and undefined operation report nothing
        add_row(OP_RESTORE, 32'h0000_0000, 1, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_UNUSED,  STAMP_MAX,     1, 2'd0, 1'b0, 32'h0000_0000);
        // commit before any begin lands on slot 0
        add_row(OP_COMMIT,  32'h0000_0000, 1, 2'd0, 1'b1, 32'h0000_0000);
        // a complete slot with zero stamp stays invisible to restore
        add_row(OP_RESTORE, STAMP_MAX,     1, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_BEGIN,   32'h0000_0005, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_COMMIT,  32'h0000_0000, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_RESTORE, 32'h0000_0000, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_BEGIN,   STAMP_MAX,     1, 2'd2, 1'b1, STAMP_MAX);
        add_row(OP_COMMIT,  32'h0000_0000, 1, 2'd2, 1'b1, STAMP_MAX);
        add_row(OP_BEGIN,   32'h0000_0007, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_COMMIT,  32'h0000_0000, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_RESTORE, 32'h0000_0000, 1, 2'd2, 1'b1, STAMP_MAX);
        // all complete: begin replaces the oldest stamp, then reuses the open slot
        add_row(OP_BEGIN,   32'h0000_0009, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_BEGIN,   32'h0000_0003, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_COMMIT,  32'h0000_0000, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_UNUSED,  32'hAAAA_AAAA, 1, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_RESTORE, 32'h5555_5555, 1, 2'd2, 1'b1, STAMP_MAX);
        // equal smallest stamps: lowest index wins
        add_row(OP_BEGIN,   32'h0000_0005, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_COMMIT,  32'h0000_0000, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_BEGIN,   32'h0000_0006, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_COMMIT,  32'h0000_0000, 0, 2'd0, 1'b0, 32'h0000_0000);
        // equal largest stamps on restore: lowest index wins
        add_row(OP_BEGIN,   STAMP_MAX,     0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_COMMIT,  32'h0000_0000, 0, 2'd0, 1'b0, 32'h0000_0000);
        add_row(OP_RESTORE, 32'h0000_0000, 1, 2'd1, 1'b1, STAMP_MAX);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
            send_item(stim_table[i].op, stim_table[i].stamp, stim_table[i].typed,
                      stim_table[i].want);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                // well-formed checkpoint: begin, then commit
                send_item(OP_BEGIN, random_stamp(), 0, none);
                send_item(OP_COMMIT, $urandom, 0, none);
                sent += 2;
            end
            else if (kind < 80)
            begin
                send_item(OP_RESTORE, $urandom, 0, none);
                sent++;
            end
            else if (kind < 87)
            begin
                // abandoned checkpoint
                send_item(OP_BEGIN, random_stamp(), 0, none);
                sent++;
            end
            else if (kind < 94)
            begin
                send_item(OP_COMMIT, $urandom, 0, none);
                sent++;
            end
            else
            begin
                send_item(OP_UNUSED, $urandom, 0, none);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (slot_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d begin, %0d commit, %0d restore and %0d undefined operations",
                 op_counts[OP_BEGIN], op_counts[OP_COMMIT], op_counts[OP_RESTORE],
                 op_counts[OP_UNUSED]);
        $display("checked %0d results in %0d cycles, %0d failures", results_checked,
                 cycle_count, fail_count);
        if (fail_count == 0 && slot_results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/csm_pkg.sv
hw/rtl/csm_cmp.sv
hw/rtl/csm_slot_store.sv
hw/rtl/checkpoint_slot_manager_core.sv
hw/rtl/csm_checker.sv
sim/checkpoint_slot_manager_core_test.sv
